[hw/rtl/mtrr_pkg.sv]
// Shared types, constants and codes for the memory type range resolver.
package mtrr_pkg;

    // Default parameter values
    localparam int MAX_RANGES_DEF = 128;
    localparam int ADDR_BITS_DEF  = 52;

    // Fixed field widths
    localparam int IDX_FIELD_W  = 7;
    localparam int BASE_FIELD_W = 52;
    localparam int END_FIELD_W  = 53;
    localparam int TYPE_W       = 3;
    localparam int PFN_W        = 40;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int COUNT_W      = 8;

    // Page size shifts; query byte address width
    localparam int SMALL_SHIFT = 12;
    localparam int LARGE_SHIFT = 21;
    localparam int QADDR_W     = PFN_W + LARGE_SHIFT;

    // Wide enough for any entry index or MAX_RANGES value below 2048
    localparam int IDX_CMP_W = 11;

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Memory type codes used by the resolution rules
    localparam logic [TYPE_W-1:0] MT_UC = 3'd0;
    localparam logic [TYPE_W-1:0] MT_WT = 3'd4;
    localparam logic [TYPE_W-1:0] MT_WB = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TYPE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT  = 8'd1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_FIELD_W-1:0]  entry_index;
        logic [BASE_FIELD_W-1:0] range_base;
        logic [END_FIELD_W-1:0]  range_end;
        logic [TYPE_W-1:0]       range_type;
        logic                    range_fixed;
        logic [PFN_W-1:0]        page_number;
        logic                    large_page;
    } t_in_item;

    typedef struct packed {
        logic [TYPE_W-1:0] mtype;
        logic              used_default;
        logic              large_page_ok;
        logic              load_rejected;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic rd_en;
        logic push;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/mtrr_ctrl.sv]
// Controller: sequences table reads for a query and hands results to the output.
module mtrr_ctrl #(
    parameter int MAX_RANGES = mtrr_pkg::MAX_RANGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_is_query,
    input  mtrr_pkg::t_dp_status                i_status,
    input  logic [$clog2(MAX_RANGES+1)-1:0]     i_active_cnt,
    output logic                                o_in_ready,
    output mtrr_pkg::t_dp_cmd                   o_cmd,
    output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] o_rd_idx
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_en;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               w_push;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_push     = (r_state == S_DONE) && i_status.out_free;

    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_en = r_rd_en;
        o_cmd.push  = w_push;
    end
    assign o_rd_idx = r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_rd_en  <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rd_en <= 1'b0;
                    if (i_accept) begin
                        r_idx   <= '0;
                        r_state <= i_is_query ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_idx < i_active_cnt) begin
                        r_rd_en  <= 1'b1;
                        r_rd_idx <= r_idx[IDX_W-1:0];
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_rd_en <= 1'b0;
                        // wait for the read and compare stages to drain
                        if (!i_status.busy) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_rd_en <= 1'b0;
                    if (w_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= i_active_cnt))
        else $error("scan index ran past active count");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_en |-> (r_state == S_SCAN))
        else $error("table read outside scan");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_state == S_IDLE) && !r_rd_en)
        else $error("controller not idle after result handoff");

endmodule

[hw/rtl/mtrr_dp.sv]
// Datapath: range table, config registers, compare and resolve stages, output register.
module mtrr_dp #(
    parameter int MAX_RANGES = mtrr_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = mtrr_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  mtrr_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_wr,
    input  logic [mtrr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtrr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  mtrr_pkg::t_dp_cmd                   i_cmd,
    input  logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] i_rd_idx,
    input  logic                                i_out_ready,
    output mtrr_pkg::t_dp_status                o_status,
    output logic [$clog2(MAX_RANGES+1)-1:0]     o_active_cnt,
    output logic                                o_out_valid,
    output mtrr_pkg::t_out_item                 o_out_item
);

    localparam int CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int END_W  = ADDR_BITS + 1;
    localparam int QA_W   = mtrr_pkg::QADDR_W;
    localparam int PFN_W  = mtrr_pkg::PFN_W;
    localparam int LSH    = mtrr_pkg::LARGE_SHIFT;
    localparam int SSH    = mtrr_pkg::SMALL_SHIFT;
    localparam int TW     = mtrr_pkg::TYPE_W;
    localparam int EXT_W  = IDX_W + mtrr_pkg::IDX_FIELD_W;

    // Range table
    logic [ADDR_BITS-1:0] mem_base  [MAX_RANGES];
    logic [END_W-1:0]     mem_end   [MAX_RANGES];
    logic [TW-1:0]        mem_code  [MAX_RANGES];
    logic                 mem_fixed [MAX_RANGES];

    // Config
    logic [TW-1:0]                    r_default;
    logic [mtrr_pkg::COUNT_W-1:0]     r_count;

    // Query context
    logic                 r_is_load;
    logic                 r_rej;
    logic                 r_large;
    logic [PFN_W-1:0]     r_pfn;
    logic [QA_W-1:0]      r_addr;

    // Read stage
    logic                 r_v1;
    logic [ADDR_BITS-1:0] r_q_base;
    logic [END_W-1:0]     r_q_end;
    logic [TW-1:0]        r_q_type;
    logic                 r_q_fixed;

    // Compare stage
    logic                 r_v2;
    logic                 r_cover;
    logic                 r_bnd;
    logic [TW-1:0]        r_c_type;
    logic                 r_c_fixed;

    // Resolve accumulators
    logic                 r_have;
    logic                 r_stop;
    logic [TW-1:0]        r_t;
    logic                 r_bnd_any;

    // Output register
    logic                 r_out_valid;
    mtrr_pkg::t_out_item  r_out_item;
    mtrr_pkg::t_out_item  w_result;

    logic                 w_reject;
    logic [EXT_W-1:0]     w_wr_ext;
    logic [IDX_W-1:0]     w_wr_addr;
    logic                 w_b_in;
    logic                 w_e_in;

    assign w_reject  = (mtrr_pkg::IDX_CMP_W'(i_in_item.entry_index)
                        >= mtrr_pkg::IDX_CMP_W'(MAX_RANGES));
    assign w_wr_ext  = EXT_W'(i_in_item.entry_index);
    assign w_wr_addr = w_wr_ext[IDX_W-1:0];

    assign o_active_cnt = (mtrr_pkg::IDX_CMP_W'(r_count) > mtrr_pkg::IDX_CMP_W'(MAX_RANGES))
                          ? CNT_W'(MAX_RANGES) : CNT_W'(r_count);

    assign o_status.busy     = i_cmd.rd_en || r_v1 || r_v2;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
            r_count   <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                mtrr_pkg::REG_DEFAULT_TYPE: r_default <= i_cfg_data[TW-1:0];
                mtrr_pkg::REG_RANGE_COUNT:  r_count   <= i_cfg_data[mtrr_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Table write on load, registered read during scan
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_in_item.cmd == mtrr_pkg::CMD_LOAD) && !w_reject) begin
            mem_base[w_wr_addr]  <= i_in_item.range_base[ADDR_BITS-1:0];
            mem_end[w_wr_addr]   <= i_in_item.range_end[END_W-1:0];
            mem_code[w_wr_addr]  <= i_in_item.range_type;
            mem_fixed[w_wr_addr] <= i_in_item.range_fixed;
        end
        if (i_cmd.rd_en) begin
            r_q_base  <= mem_base[i_rd_idx];
            r_q_end   <= mem_end[i_rd_idx];
            r_q_type  <= mem_code[i_rd_idx];
            r_q_fixed <= mem_fixed[i_rd_idx];
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_is_load <= (i_in_item.cmd == mtrr_pkg::CMD_LOAD);
            r_rej     <= (i_in_item.cmd == mtrr_pkg::CMD_LOAD) && w_reject;
            r_large   <= i_in_item.large_page;
            r_pfn     <= i_in_item.page_number;
            r_addr    <= i_in_item.large_page
                         ? {i_in_item.page_number, LSH'(0)}
                         : QA_W'({i_in_item.page_number, SSH'(0)});
        end
    end

    // A boundary lies strictly inside an aligned 2 MB page when its upper bits
    // name the page and its offset bits are nonzero.
    assign w_b_in = (PFN_W'(r_q_base[ADDR_BITS-1:LSH]) == r_pfn)
                    && (r_q_base[LSH-1:0] != '0);
    assign w_e_in = (PFN_W'(r_q_end[END_W-1:LSH]) == r_pfn)
                    && (r_q_end[LSH-1:0] != '0);

    // Compare stage
    always_ff @(posedge i_clk) begin
        r_cover   <= (r_addr >= QA_W'(r_q_base)) && (r_addr < QA_W'(r_q_end));
        r_bnd     <= w_b_in || w_e_in;
        r_c_type  <= r_q_type;
        r_c_fixed <= r_q_fixed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    // Resolve stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_stop    <= 1'b0;
            r_bnd_any <= 1'b0;
            r_t       <= '0;
        end else if (i_accept) begin
            r_have    <= 1'b0;
            r_stop    <= 1'b0;
            r_bnd_any <= 1'b0;
            r_t       <= '0;
        end else if (r_v2) begin
            if (r_bnd) begin
                r_bnd_any <= 1'b1;
            end
            if (r_cover && !r_stop) begin
                priority if (r_c_fixed) begin
                    r_t    <= r_c_type;
                    r_have <= 1'b1;
                    r_stop <= 1'b1;
                end else if (!r_have) begin
                    r_t    <= r_c_type;
                    r_have <= 1'b1;
                end else if (r_t == r_c_type) begin
                    r_t <= r_t;
                end else if ((r_t == mtrr_pkg::MT_UC) || (r_c_type == mtrr_pkg::MT_UC)) begin
                    r_t    <= mtrr_pkg::MT_UC;
                    r_stop <= 1'b1;
                end else if (((r_t == mtrr_pkg::MT_WB) && (r_c_type == mtrr_pkg::MT_WT))
                          || ((r_t == mtrr_pkg::MT_WT) && (r_c_type == mtrr_pkg::MT_WB))) begin
                    r_t <= mtrr_pkg::MT_WT;
                end else begin
                    r_t    <= mtrr_pkg::MT_UC;
                    r_stop <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_result = '0;
        if (r_is_load) begin
            w_result.load_rejected = r_rej;
        end else begin
            w_result.mtype         = r_have ? r_t : r_default;
            w_result.used_default  = !r_have;
            w_result.large_page_ok = r_large && !r_bnd_any;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stop_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> r_have)
        else $error("resolve stopped without a covering entry");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !i_out_ready) |=> r_out_valid)
        else $error("pushed item lost from output register");

endmodule

[hw/rtl/mtrr_memory_type_resolver_top.sv]
// Top level of the memory type range resolver: ports, controller and datapath.
//
//  channel  direction  handshake                     payload
//  in       to block   i_in_valid / o_in_ready       i_in_item  (t_in_item)
//  out      from block o_out_valid / i_out_ready     o_out_item (t_out_item)
//  cfg      to block   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  A load item writes one table slot at acceptance; the controller then moves
//  to its done state, pushes the result into the output register once that is
//  free, and returns to idle, where the next item can be taken.
//  A query scans entries 0 .. n-1, n = min(range_count, MAX_RANGES), one table
//  read per cycle from the single table read port, through a read stage, a
//  compare stage and a resolve stage, then waits for these stages to drain.
//  One item is in work at a time; a new item is taken while a previous result
//  still waits in the output register, and a finished result waits for the
//  output register to free before the next item is accepted.
//  Synchronous active-low reset clears control state and the config registers;
//  the range table is not cleared. Config writes are always accepted.
module mtrr_memory_type_resolver_top #(
    parameter int MAX_RANGES = mtrr_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = mtrr_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mtrr_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mtrr_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mtrr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtrr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic                   w_accept;
    logic                   w_cfg_wr;
    mtrr_pkg::t_dp_cmd      w_cmd;
    mtrr_pkg::t_dp_status   w_status;
    logic [CNT_W-1:0]       w_active_cnt;
    logic [IDX_W-1:0]       w_rd_idx;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    mtrr_ctrl #(
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_is_query   (i_in_item.cmd == mtrr_pkg::CMD_QUERY),
        .i_status     (w_status),
        .i_active_cnt (w_active_cnt),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd),
        .o_rd_idx     (w_rd_idx)
    );

    mtrr_dp #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_in_item    (i_in_item),
        .i_cfg_wr     (w_cfg_wr),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .i_rd_idx     (w_rd_idx),
        .i_out_ready  (i_out_ready),
        .o_status     (w_status),
        .o_active_cnt (w_active_cnt),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

[bench/tb_mtrr_memory_type_resolver_top.sv]
// Self-checking bench for the memory type range resolver: directed table, random phases.
module tb_mtrr_memory_type_resolver_top;
    import mtrr_pkg::*;

    localparam int MAX_SLOTS      = MAX_RANGES_DEF;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CFG_SETTLE     = 8;
    localparam int END_SETTLE     = 150;   // longest scan plus pipeline, with margin
    localparam int IDLE_PCT       = 13;

    // Type codes that the package does not name
    localparam logic [TYPE_W-1:0] TYPE_WC  = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_WP  = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_TOP = 3'd7;

    localparam logic [END_FIELD_W-1:0]  END_MAX    = 53'h1 << BASE_FIELD_W;
    localparam logic [BASE_FIELD_W-1:0] TOP_REGION = 52'hF_FFFF_FE00_0000;
    localparam logic [63:0]             LARGE_SPAN = 64'h1 << LARGE_SHIFT;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_CLEAR} t_row_kind;

    // One line of the directed table
    typedef struct packed {
        t_row_kind   kind;
        t_in_item    item;
        logic        typed;    // want holds the expected result
        t_out_item   want;
        logic [2:0]  dflt;
        logic [7:0]  count;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block's table and registers
    logic [BASE_FIELD_W-1:0] base_tbl [MAX_SLOTS];
    logic [END_FIELD_W-1:0]  end_tbl  [MAX_SLOTS];
    logic [TYPE_W-1:0]       type_tbl [MAX_SLOTS];
    logic                    fixed_tbl[MAX_SLOTS];
    logic [TYPE_W-1:0]       default_reg = '0;
    logic [COUNT_W-1:0]      scan_count = '0;

    t_out_item pending_results[$];
    t_out_item wanted;
    t_row dir_rows[$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int random_sent = 0;
    logic steady = 1'b0;   // no idling on either side while set

    mtrr_memory_type_resolver_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int active_slots();
        return (int'(scan_count) > MAX_SLOTS) ? MAX_SLOTS : int'(scan_count);
    endfunction

    // Resolve one item against the shadow table; loads update the table.
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item r;
        logic [63:0] addr, span_end, b, e;
        logic [TYPE_W-1:0] t, rt;
        logic have, stop;
        int n;
        r = '0;
        if (it.cmd == CMD_LOAD) begin
            if (int'(it.entry_index) >= MAX_SLOTS) begin
                r.load_rejected = 1'b1;
            end else begin
                base_tbl[it.entry_index]  = it.range_base;
                end_tbl[it.entry_index]   = it.range_end;
                type_tbl[it.entry_index]  = it.range_type;
                fixed_tbl[it.entry_index] = it.range_fixed;
            end
            return r;
        end
        n = active_slots();
        addr = 64'(it.page_number) << (it.large_page ? LARGE_SHIFT : SMALL_SHIFT);
        have = 1'b0;
        stop = 1'b0;
        t = MT_UC;
        for (int i = 0; i < n && !stop; i++) begin
            if (addr >= 64'(base_tbl[i]) && addr < 64'(end_tbl[i])) begin
                rt = type_tbl[i];
                if (fixed_tbl[i]) begin
                    t = rt;
                    have = 1'b1;
                    stop = 1'b1;
                end else if (!have) begin
                    t = rt;
                    have = 1'b1;
                end else if (t != rt) begin
                    // UC dominates, WB with WT degrades to WT, all else is UC
                    if (t == MT_UC || rt == MT_UC) begin
                        t = MT_UC;
                        stop = 1'b1;
                    end else if ((t == MT_WB && rt == MT_WT) || (t == MT_WT && rt == MT_WB)) begin
                        t = MT_WT;
                    end else begin
                        t = MT_UC;
                        stop = 1'b1;
                    end
                end
            end
        end
        r.mtype = have ? t : default_reg;
        r.used_default = !have;
        if (it.large_page) begin
            span_end = addr + LARGE_SPAN;
            r.large_page_ok = 1'b1;
            for (int i = 0; i < n; i++) begin
                b = 64'(base_tbl[i]);
                e = 64'(end_tbl[i]);
                if ((b > addr && b < span_end) || (e > addr && e < span_end))
                    r.large_page_ok = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        logic [63:0] a, b, c;
        a = rand64();
        b = rand64();
        c = rand64();
        it.cmd         = a[0];
        it.entry_index = a[7:1];
        it.range_base  = b[51:0];
        it.range_end   = c[52] ? END_MAX : {1'b0, c[51:0]};
        it.range_type  = a[10:8];
        it.range_fixed = a[11];
        it.page_number = a[51:12];
        it.large_page  = a[52];
        return it;
    endfunction

    // Range near the phase region, on 4 KB, 2 MB or byte grain.
    function automatic t_in_item rand_load(input logic [BASE_FIELD_W-1:0] region);
        t_in_item it;
        logic [63:0] w, v, base, span, last;
        int n;
        it = rand_item();
        w = rand64();
        v = rand64();
        n = active_slots();
        it.cmd = CMD_LOAD;
        if (n > 0 && w[1:0] != 2'd0)
            it.entry_index = 7'($urandom_range(0, n - 1));
        case (w[3:2])
            2'd0: base = 64'(region) + {40'b0, w[23:12], 12'b0};
            2'd1: base = 64'(region) + {40'b0, w[26:24], 21'b0};
            2'd2: base = 64'(region) + {40'b0, w[47:24]};
            default: base = 64'(region);
        endcase
        case (v[1:0])
            2'd0: span = {40'b0, v[23:12], 12'b0};
            2'd1: span = (64'(v[26:24]) + 64'd1) << LARGE_SHIFT;
            2'd2: span = {40'b0, v[47:24]};
            default: span = '0;
        endcase
        // occasionally an inverted range, which covers nothing
        if (v[63:60] == 4'd0)
            last = (span > base) ? 64'd0 : base - span;
        else
            last = base + span;
        if (last > 64'(END_MAX))
            last = 64'(END_MAX);
        it.range_base = base[51:0];
        it.range_end  = last[52:0];
        if (v[10:8] == 3'd0) begin
            it.range_type = v[13:11];
        end else begin
            case (v[16:14])
                3'd0: it.range_type = MT_UC;
                3'd1: it.range_type = TYPE_WC;
                3'd2, 3'd7: it.range_type = MT_WT;
                3'd3: it.range_type = TYPE_WP;
                default: it.range_type = MT_WB;
            endcase
        end
        it.range_fixed = (v[19:17] == 3'd0);
        return it;
    endfunction

    // Page in the region, at / just below a boundary of an active entry, or anywhere.
    function automatic t_in_item rand_query(input logic [BASE_FIELD_W-1:0] region);
        t_in_item it;
        logic [63:0] w, addr, target;
        int n, slot;
        it = rand_item();
        w = rand64();
        n = active_slots();
        it.cmd = CMD_QUERY;
        it.large_page = (w[1:0] == 2'd0);
        if (w[4:2] == 3'd7)
            return it;
        addr = 64'(region) + {40'b0, w[47:24]};
        if (n > 0 && w[4:2] < 3'd3) begin
            slot = $urandom_range(0, n - 1);
            target = w[5] ? 64'(base_tbl[slot]) : 64'(end_tbl[slot]);
            addr = w[6] ? target - 64'd1 : target;
        end
        it.page_number = it.large_page ? addr[60:21] : addr[51:12];
        return it;
    endfunction

    function automatic t_row row_query(input logic [PFN_W-1:0] pfn, input logic big,
                                       input logic typed, input t_out_item want);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = rand_item();
        r.item.cmd = CMD_QUERY;
        r.item.page_number = pfn;
        r.item.large_page = big;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_row row_load(input int slot, input logic [BASE_FIELD_W-1:0] base,
                                      input logic [END_FIELD_W-1:0] last,
                                      input logic [TYPE_W-1:0] code, input logic fixed);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = rand_item();
        r.item.cmd = CMD_LOAD;
        r.item.entry_index = 7'(slot);
        r.item.range_base = base;
        r.item.range_end = last;
        r.item.range_type = code;
        r.item.range_fixed = fixed;
        r.typed = 1'b1;       // a load always answers all zero
        return r;
    endfunction

    function automatic t_row row_cfg(input logic [2:0] dflt, input logic [7:0] count);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.dflt = dflt;
        r.count = count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one item; at acceptance record what it must produce.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 20);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        predicted = predict_result(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Lower valid and let every outstanding result come back.
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes both registers; the upper bits of the default type write carry junk
    // that must be dropped.
    task automatic set_config(input logic [2:0] dflt, input logic [7:0] count);
        logic [63:0] w;
        w = rand64();
        for (int r = 0; r < 2; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? REG_DEFAULT_TYPE : REG_RANGE_COUNT;
            cfg_data  <= (r == 0) ? {w[4:0], dflt} : count;
            @(negedge clk);
            while (!cfg_ready) @(negedge clk);
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        default_reg = dflt;
        scan_count = count;
    endtask

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Handshake values are settled by the falling edge, so sample there.
    always @(negedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(out_item), 64'd0);
            end else begin
                wanted = pending_results.pop_front();
                if (out_item.mtype !== wanted.mtype)
                    report_mismatch("mtype", 64'(out_item.mtype), 64'(wanted.mtype));
                if (out_item.used_default !== wanted.used_default)
                    report_mismatch("used_default", 64'(out_item.used_default),
                                    64'(wanted.used_default));
                if (out_item.large_page_ok !== wanted.large_page_ok)
                    report_mismatch("large_page_ok", 64'(out_item.large_page_ok),
                                    64'(wanted.large_page_ok));
                if (out_item.load_rejected !== wanted.load_rejected)
                    report_mismatch("load_rejected", 64'(out_item.load_rejected),
                                    64'(wanted.load_rejected));
            end
            results_seen++;
        end
    end

    // Watchdog: consecutive cycles with no handshake on any channel
    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_mtrr_memory_type_resolver_top failed");
        $finish;
    end

    initial begin
        t_row row;
        t_in_item it;
        logic [BASE_FIELD_W-1:0] region;
        logic [63:0] w;
        logic [7:0] count;
        int sel, phase, phase_len;

        // Directed table. Slots 0..4 build a small overlap picture around 256 MB;
        // slot 3 is a fixed range over all memory, slot 4 sits at the top address.
        dir_rows.push_back(row_query(40'h0, 1'b0, 1'b1, {MT_UC, 1'b1, 1'b0, 1'b0}));
        dir_rows.push_back(row_query(40'hFF_FFFF_FFFF, 1'b1, 1'b1, {MT_UC, 1'b1, 1'b1, 1'b0}));
        dir_rows.push_back(row_load(5, 52'h1234_5000, 53'h1234_6000, MT_WB, 1'b0));
        dir_rows.push_back(row_cfg(TYPE_TOP, 8'd0));
        dir_rows.push_back(row_query(40'hFF_FFFF_FFFF, 1'b0, 1'b1,
                                     {TYPE_TOP, 1'b1, 1'b0, 1'b0}));
        dir_rows.push_back(row_query(40'h0, 1'b1, 1'b1, {TYPE_TOP, 1'b1, 1'b1, 1'b0}));
        row = '0;
        row.kind = ROW_CLEAR;
        dir_rows.push_back(row);
        dir_rows.push_back(row_load(0, 52'h1000_0000, 53'h2000_0000, MT_WB, 1'b0));
        dir_rows.push_back(row_load(1, 52'h1800_0000, 53'h1900_0000, MT_WT, 1'b0));
        dir_rows.push_back(row_load(2, 52'h1880_0000, 53'h1881_0000, MT_UC, 1'b0));
        dir_rows.push_back(row_cfg(TYPE_TOP, 8'd3));
        dir_rows.push_back(row_query(40'h1_0000, 1'b0, 1'b0, '0));   // WB alone
        dir_rows.push_back(row_query(40'h1_8000, 1'b0, 1'b0, '0));   // WB under WT
        dir_rows.push_back(row_query(40'h1_8800, 1'b0, 1'b0, '0));   // UC overlap
        dir_rows.push_back(row_query(40'h80, 1'b1, 1'b0, '0));       // clean 2 MB page
        dir_rows.push_back(row_query(40'hC4, 1'b1, 1'b0, '0));       // end inside page
        dir_rows.push_back(row_query(40'h3_0000, 1'b0, 1'b0, '0));   // no cover
        dir_rows.push_back(row_load(3, 52'h0, END_MAX, TYPE_WP, 1'b1));
        dir_rows.push_back(row_load(4, 52'hF_FFFF_FFFF_FFFF, END_MAX, TYPE_WC, 1'b0));
        dir_rows.push_back(row_cfg(3'd0, 8'd255));                    // count past table
        dir_rows.push_back(row_query(40'h1_0000, 1'b0, 1'b0, '0));   // fixed wins
        dir_rows.push_back(row_query(40'hFF_FFFF_FFFF, 1'b0, 1'b0, '0));
        dir_rows.push_back(row_query(40'h1_8800, 1'b0, 1'b0, '0));   // UC before fixed
        dir_rows.push_back(row_load(1, 52'h1000_0000, 53'h1100_0000, TYPE_WC, 1'b0));
        dir_rows.push_back(row_query(40'h1_0000, 1'b0, 1'b0, '0));   // WB meets WC
        dir_rows.push_back(row_query(40'h7FFF_FFFF, 1'b1, 1'b0, '0)); // top 2 MB page

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG: begin
                    wait_drained(CFG_SETTLE);
                    set_config(row.dflt, row.count);
                end
                ROW_CLEAR: begin
                    // every slot gets an empty range, so any count is safe to scan
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        it = rand_item();
                        it.cmd = CMD_LOAD;
                        it.entry_index = 7'(s);
                        it.range_base = '0;
                        it.range_end = '0;
                        send_item(it, 1'b1, '0);
                    end
                end
                default: send_item(row.item, row.typed, row.want);
            endcase
        end

        // Random phases: each picks a region, a default type and a scan length
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                count = 8'd0;
            else if (sel == 1)
                count = 8'(MAX_SLOTS);
            else if (sel == 2)
                count = 8'($urandom_range(MAX_SLOTS + 1, 255));
            else if (sel < 6)
                count = 8'($urandom_range(9, 40));
            else
                count = 8'($urandom_range(1, 8));
            wait_drained(CFG_SETTLE);
            set_config(3'($urandom_range(0, 7)), count);

            w = rand64();
            sel = $urandom_range(0, 7);
            if (sel == 0)
                region = '0;
            else if (sel == 1 || {w[51:21], 21'b0} > TOP_REGION)
                region = TOP_REGION;
            else
                region = {w[51:21], 21'b0};

            phase_len = $urandom_range(15, 50);
            for (int k = 0; k < phase_len; k++) begin
                steady = (random_sent >= 400 && random_sent < 650);
                // hold off until the block has answered everything
                if (k == phase_len / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
                    wait_drained(1);
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    it = rand_item();
                else if (sel < 45)
                    it = rand_load(region);
                else
                    it = rand_query(region);
                send_item(it, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end
        steady = 1'b0;

        wait_drained(END_SETTLE);
        if (mismatches == 0)
            $display("tb_mtrr_memory_type_resolver_top passed");
        else
            $display("tb_mtrr_memory_type_resolver_top failed");
        $finish;
    end

endmodule
